/* design/xfr_pkg.sv */
`default_nettype none
package xfr_pkg;

  localparam int FRAME_BYTES = 132;
  localparam int DATA_BYTES  = 128;
  localparam int WORDS       = DATA_BYTES / 4;
  localparam int WCNT_W      = $clog2(WORDS + 1);

  localparam logic [7:0] LEAD_SOH = 8'h01;
  localparam logic [7:0] LEAD_EOT = 8'h04;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_ACK   = 2'd1;
  localparam logic [1:0] ACT_NAK   = 2'd2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_BASE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EOT_WAIT = 2'd3;

  localparam logic [31:0] BASE_RST     = 32'h0800_5000;
  localparam logic [31:0] LIMIT_RST    = 32'h0802_0000;
  localparam logic [7:0]  TIMEOUT_RST  = 8'd200;
  localparam logic [7:0]  EOT_WAIT_RST = 8'd20;

  typedef struct packed {
    logic [31:0] base;
    logic [31:0] limit;
    logic [7:0]  timeout;
    logic [7:0]  eot_wait;
    logic        base_load;
  } cfg_t;

endpackage
`default_nettype wire

/* design/xfr_if.sv */
`default_nettype none
interface xfr_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;

  modport source(output valid, output func, output rx_byte, input ready);
  modport sink(input valid, input func, input rx_byte, output ready);
endinterface

interface xfr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] flash_address;
  logic [31:0] flash_word;
  logic        session_done;
  logic [31:0] end_address;
  logic        last;

  modport source(output valid, output action, output flash_address, output flash_word,
                 output session_done, output end_address, output last, input ready);
  modport sink(input valid, input action, input flash_address, input flash_word,
               input session_done, input end_address, input last, output ready);
endinterface
`default_nettype wire

/* design/xmodem_frame_receiver_unit.sv */
`default_nettype none
// XMODEM frame receiver. Each input beat is a received byte or a timer tick and is taken
// whenever the block is idle and its result register is free. A frame that starts
// with SOH and is below the limit address is unloaded as 32 flash write beats and an ACK:
// one word per cycle while the output is not stalled, paced by the single row
// read port of the frame store and by output back-pressure; no input is taken during that
// time. Every other judgement gives one beat (ACK, NAK or the final ACK with session done).
// The frame store needs no clearing pass: the byte count masks stale entries on read.
module xmodem_frame_receiver_unit #(
  parameter int BUF_DEPTH = 140
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  xfr_in_if.sink                              in_ch,
  xfr_out_if.source                           out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [xfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [xfr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int ROWS = (BUF_DEPTH + 4) / 4;
  localparam int RW   = $clog2(ROWS);

  logic [31:0]   base_r, base_nxt;
  logic [31:0]   limit_r, limit_nxt;
  logic [7:0]    timeout_r, timeout_nxt;
  logic [7:0]    eot_wait_r, eot_wait_nxt;
  xfr_pkg::cfg_t cfg;

  logic          st_wr_en;
  logic [RW-1:0] st_wr_row;
  logic [1:0]    st_wr_lane;
  logic [7:0]    st_wr_byte;
  logic          st_rd_en;
  logic [RW-1:0] st_rd_row;
  logic [31:0]   st_rd_data;

  always_comb begin
    base_nxt     = base_r;
    limit_nxt    = limit_r;
    timeout_nxt  = timeout_r;
    eot_wait_nxt = eot_wait_r;
    if (cfg_we) begin
      case (cfg_index)
        xfr_pkg::REG_BASE:     base_nxt     = cfg_wdata;
        xfr_pkg::REG_LIMIT:    limit_nxt    = cfg_wdata;
        xfr_pkg::REG_TIMEOUT:  timeout_nxt  = cfg_wdata[7:0];
        xfr_pkg::REG_EOT_WAIT: eot_wait_nxt = cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r     <= xfr_pkg::BASE_RST;
      limit_r    <= xfr_pkg::LIMIT_RST;
      timeout_r  <= xfr_pkg::TIMEOUT_RST;
      eot_wait_r <= xfr_pkg::EOT_WAIT_RST;
    end else begin
      base_r     <= base_nxt;
      limit_r    <= limit_nxt;
      timeout_r  <= timeout_nxt;
      eot_wait_r <= eot_wait_nxt;
    end
  end

  always_comb begin
    cfg.base      = base_nxt;
    cfg.limit     = limit_r;
    cfg.timeout   = timeout_r;
    cfg.eot_wait  = eot_wait_r;
    cfg.base_load = cfg_we && (cfg_index == xfr_pkg::REG_BASE);
  end

  xfr_store #(
    .BUF_DEPTH(BUF_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_row  (st_wr_row),
    .wr_lane (st_wr_lane),
    .wr_byte (st_wr_byte),
    .rd_en   (st_rd_en),
    .rd_row  (st_rd_row),
    .rd_data (st_rd_data)
  );

  xfr_seq #(
    .BUF_DEPTH(BUF_DEPTH)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .st_wr_en   (st_wr_en),
    .st_wr_row  (st_wr_row),
    .st_wr_lane (st_wr_lane),
    .st_wr_byte (st_wr_byte),
    .st_rd_en   (st_rd_en),
    .st_rd_row  (st_rd_row),
    .st_rd_data (st_rd_data)
  );

endmodule
`default_nettype wire

/* design/xfr_store.sv */
`default_nettype none
module xfr_store #(
  parameter int BUF_DEPTH = 140,
  localparam int ROWS = (BUF_DEPTH + 4) / 4,
  localparam int RW   = $clog2(ROWS)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [RW-1:0] wr_row,
  input  wire logic [1:0]    wr_lane,
  input  wire logic [7:0]    wr_byte,
  input  wire logic          rd_en,
  input  wire logic [RW-1:0] rd_row,
  output logic [31:0]        rd_data
);

  logic [3:0][7:0] mem_r [ROWS];
  logic [31:0]     rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_row][wr_lane] <= wr_byte;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_row];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

/* design/xfr_seq.sv */
`default_nettype none
module xfr_seq #(
  parameter int BUF_DEPTH = 140,
  localparam int ROWS = (BUF_DEPTH + 4) / 4,
  localparam int RW   = $clog2(ROWS),
  localparam int CW   = $clog2(BUF_DEPTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire xfr_pkg::cfg_t cfg,
  xfr_in_if.sink             in_ch,
  xfr_out_if.source          out_ch,
  output logic               st_wr_en,
  output logic [RW-1:0]      st_wr_row,
  output logic [1:0]         st_wr_lane,
  output logic [7:0]         st_wr_byte,
  output logic               st_rd_en,
  output logic [RW-1:0]      st_rd_row,
  input  wire logic [31:0]   st_rd_data
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WORDS = 2'd1;
  localparam logic [1:0] ST_ACK   = 2'd2;

  localparam logic [1:0] PH_RECV = 2'd0;
  localparam logic [1:0] PH_EOTW = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  localparam logic [CW-1:0] BUF_CNT   = CW'(BUF_DEPTH);
  localparam logic [CW-1:0] FRAME_CNT = CW'(xfr_pkg::FRAME_BYTES);
  localparam logic [xfr_pkg::WCNT_W-1:0] WORD_CNT = xfr_pkg::WCNT_W'(xfr_pkg::WORDS);

  logic [1:0]                    st_r, st_nxt;
  logic [1:0]                    ph_r, ph_nxt;
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic [7:0]                    timer_r, timer_nxt;
  logic [31:0]                   wa_r, wa_nxt;
  logic [7:0]                    lead_r, lead_nxt;
  logic [31:0]                   addr_r, addr_nxt;
  logic [xfr_pkg::WCNT_W-1:0]    issue_r, issue_nxt;
  logic [xfr_pkg::WCNT_W-2:0]    wk_r, wk_nxt;
  logic                          pend_r, pend_nxt;

  logic                          ov_r, ov_nxt;
  logic [1:0]                    o_act_r, o_act_nxt;
  logic [31:0]                   o_addr_r, o_addr_nxt;
  logic [31:0]                   o_word_r, o_word_nxt;
  logic                          o_done_r, o_done_nxt;
  logic [31:0]                   o_end_r, o_end_nxt;
  logic                          o_last_r, o_last_nxt;

  logic                          slot_free;
  logic                          acc;
  logic                          cnt_inc;
  logic [CW-1:0]                 pos;
  logic [CW-1:0]                 cnt_new;
  logic [7:0]                    lead_j;
  logic [7:0]                    timer_dec;
  logic                          judge;
  logic                          consume;
  logic                          issue;
  logic [31:0]                   word_m;
  logic [31:0]                   addr_sum;

  assign addr_sum = addr_r + 32'd4;

  always_comb begin
    st_nxt     = st_r;
    ph_nxt     = ph_r;
    cnt_nxt    = cnt_r;
    timer_nxt  = timer_r;
    wa_nxt     = wa_r;
    lead_nxt   = lead_r;
    addr_nxt   = addr_r;
    issue_nxt  = issue_r;
    wk_nxt     = wk_r;
    pend_nxt   = pend_r;
    o_act_nxt  = o_act_r;
    o_addr_nxt = o_addr_r;
    o_word_nxt = o_word_r;
    o_done_nxt = o_done_r;
    o_end_nxt  = o_end_r;
    o_last_nxt = o_last_r;

    slot_free    = !ov_r || out_ch.ready;
    ov_nxt       = ov_r && !out_ch.ready;
    in_ch.ready  = (st_r == ST_IDLE) && slot_free;
    acc          = in_ch.valid && in_ch.ready;

    cnt_inc   = cnt_r < BUF_CNT;
    pos       = cnt_r + CW'(1);
    cnt_new   = (!in_ch.func && cnt_inc) ? pos : cnt_r;
    lead_j    = (!in_ch.func && cnt_r == '0) ? in_ch.rx_byte : lead_r;
    timer_dec = (timer_r != 8'd0) ? timer_r - 8'd1 : 8'd0;
    judge     = 1'b0;

    st_wr_en   = 1'b0;
    st_wr_row  = RW'(pos >> 2);
    st_wr_lane = pos[1:0];
    st_wr_byte = in_ch.rx_byte;

    for (int j = 0; j < 4; j++) begin
      word_m[8*j +: 8] = (((CW'(wk_r) << 2) + CW'(3 + j)) < cnt_r) ?
                         st_rd_data[8*j +: 8] : 8'd0;
    end

    consume   = (st_r == ST_WORDS) && pend_r && slot_free;
    issue     = (st_r == ST_WORDS) && (issue_r != WORD_CNT) && (!pend_r || consume);
    st_rd_en  = issue;
    st_rd_row = RW'(issue_r) + RW'(1);

    if (acc && ph_r != PH_DONE) begin
      if (!in_ch.func) begin
        st_wr_en = cnt_inc;
        cnt_nxt  = cnt_new;
        lead_nxt = lead_j;
        judge    = (ph_r == PH_RECV) && (cnt_new >= FRAME_CNT);
      end else begin
        timer_nxt = timer_dec;
        if (timer_dec == 8'd0) begin
          if (ph_r == PH_RECV) begin
            judge = 1'b1;
          end else begin
            ov_nxt     = 1'b1;
            o_act_nxt  = xfr_pkg::ACT_ACK;
            o_addr_nxt = '0;
            o_word_nxt = '0;
            o_done_nxt = 1'b1;
            o_end_nxt  = wa_r;
            o_last_nxt = 1'b1;
            ph_nxt     = PH_DONE;
          end
        end
      end

      if (judge) begin
        o_addr_nxt = '0;
        o_word_nxt = '0;
        o_done_nxt = 1'b0;
        o_end_nxt  = '0;
        o_last_nxt = 1'b1;
        if (cnt_new != '0 && lead_j == xfr_pkg::LEAD_SOH && wa_r < cfg.limit) begin
          st_nxt    = ST_WORDS;
          issue_nxt = '0;
          pend_nxt  = 1'b0;
          addr_nxt  = wa_r;
        end else if (cnt_new != '0 && lead_j == xfr_pkg::LEAD_EOT) begin
          ov_nxt    = 1'b1;
          o_act_nxt = xfr_pkg::ACT_ACK;
          ph_nxt    = PH_EOTW;
          timer_nxt = cfg.eot_wait;
        end else begin
          ov_nxt    = 1'b1;
          o_act_nxt = (cnt_new != '0 && lead_j == xfr_pkg::LEAD_SOH) ?
                      xfr_pkg::ACT_ACK : xfr_pkg::ACT_NAK;
          cnt_nxt   = '0;
          timer_nxt = cfg.timeout;
        end
      end
    end

    if (issue) begin
      issue_nxt = issue_r + xfr_pkg::WCNT_W'(1);
      wk_nxt    = issue_r[xfr_pkg::WCNT_W-2:0];
    end
    if (issue) begin
      pend_nxt = 1'b1;
    end else if (consume) begin
      pend_nxt = 1'b0;
    end

    if (consume) begin
      ov_nxt     = 1'b1;
      o_act_nxt  = xfr_pkg::ACT_WRITE;
      o_addr_nxt = addr_r;
      o_word_nxt = word_m;
      o_done_nxt = 1'b0;
      o_end_nxt  = '0;
      o_last_nxt = 1'b0;
      addr_nxt   = addr_sum;
      if (issue_r == WORD_CNT) begin
        st_nxt = ST_ACK;
      end
    end

    if (st_r == ST_ACK && slot_free) begin
      ov_nxt     = 1'b1;
      o_act_nxt  = xfr_pkg::ACT_ACK;
      o_addr_nxt = '0;
      o_word_nxt = '0;
      o_done_nxt = 1'b0;
      o_end_nxt  = '0;
      o_last_nxt = 1'b1;
      wa_nxt     = addr_r;
      cnt_nxt    = '0;
      timer_nxt  = cfg.timeout;
      st_nxt     = ST_IDLE;
    end

    if (cfg.base_load) begin
      wa_nxt = cfg.base;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      ph_r    <= PH_RECV;
      cnt_r   <= '0;
      timer_r <= xfr_pkg::TIMEOUT_RST;
      wa_r    <= xfr_pkg::BASE_RST;
      issue_r <= '0;
      pend_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      ph_r    <= ph_nxt;
      cnt_r   <= cnt_nxt;
      timer_r <= timer_nxt;
      wa_r    <= wa_nxt;
      issue_r <= issue_nxt;
      pend_r  <= pend_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lead_r   <= lead_nxt;
    addr_r   <= addr_nxt;
    wk_r     <= wk_nxt;
    o_act_r  <= o_act_nxt;
    o_addr_r <= o_addr_nxt;
    o_word_r <= o_word_nxt;
    o_done_r <= o_done_nxt;
    o_end_r  <= o_end_nxt;
    o_last_r <= o_last_nxt;
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.action        = o_act_r;
  assign out_ch.flash_address = o_addr_r;
  assign out_ch.flash_word    = o_word_r;
  assign out_ch.session_done  = o_done_r;
  assign out_ch.end_address   = o_end_r;
  assign out_ch.last          = o_last_r;

endmodule
`default_nettype wire

/* test/tb_xmodem_frame_receiver_unit.sv */
`timescale 1ns / 100ps
module tb_xmodem_frame_receiver_unit;

  localparam int STORE_DEPTH    = 140;
  localparam int QUIET_CYCLES   = 40;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 25;

  typedef enum logic [1:0] {RECEIVING, EOT_WAIT, SESSION_DONE} session_t;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } rx_event_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] flash_address;
    logic [31:0] flash_word;
    logic        session_done;
    logic [31:0] end_address;
    logic        last;
  } beat_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [xfr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [xfr_pkg::CFG_DATA_W-1:0] cfg_wdata;

  xfr_in_if  rx_ch();
  xfr_out_if tx_ch();

  xmodem_frame_receiver_unit #(.BUF_DEPTH(STORE_DEPTH)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(rx_ch),
    .out_ch(tx_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  rx_event_t rx_events[$];
  rx_event_t offered;
  beat_t     expected_beats[$];
  beat_t     want;

  logic [7:0]  frame_buf [STORE_DEPTH];
  int          buf_fill;
  logic [7:0]  tick_count;
  logic [31:0] next_addr;
  logic [31:0] limit_reg;
  logic [7:0]  timeout_reg;
  logic [7:0]  eot_wait_reg;
  session_t    session;

  int fail_count;
  int stall_cycles;
  int hold_left;
  int queued_items;
  bit held_once;
  bit calm;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic clear_frame();
    for (int i = 0; i < STORE_DEPTH; i++) frame_buf[i] = 8'h00;
    buf_fill = 0;
  endtask

  task automatic queue_beat(logic [1:0] act, logic [31:0] addr, logic [31:0] word,
                            logic done, logic [31:0] end_addr);
    expected_beats.push_back('{act, addr, word, done, end_addr, 1'b0});
  endtask

  task automatic judge_frame();
    logic [31:0] addr;
    if (buf_fill == 0) begin
      clear_frame();
      queue_beat(xfr_pkg::ACT_NAK, '0, '0, 1'b0, '0);
    end else if (frame_buf[0] == xfr_pkg::LEAD_SOH) begin
      if (next_addr < limit_reg) begin
        addr = next_addr;
        for (int i = 0; i < xfr_pkg::DATA_BYTES; i += 4) begin
          queue_beat(xfr_pkg::ACT_WRITE, addr,
                     {frame_buf[i+6], frame_buf[i+5], frame_buf[i+4], frame_buf[i+3]},
                     1'b0, '0);
          addr += 32'd4;
        end
        next_addr += xfr_pkg::DATA_BYTES;
      end
      clear_frame();
      queue_beat(xfr_pkg::ACT_ACK, '0, '0, 1'b0, '0);
    end else if (frame_buf[0] == xfr_pkg::LEAD_EOT) begin
      queue_beat(xfr_pkg::ACT_ACK, '0, '0, 1'b0, '0);
      session = EOT_WAIT;
      tick_count = eot_wait_reg;
      return;
    end else begin
      clear_frame();
      queue_beat(xfr_pkg::ACT_NAK, '0, '0, 1'b0, '0);
    end
    tick_count = timeout_reg;
  endtask

  task automatic predict_beat(logic func, logic [7:0] rx_byte);
    int    n0;
    beat_t tail;
    n0 = expected_beats.size();
    if (session == SESSION_DONE) return;
    if (!func) begin
      if (buf_fill < STORE_DEPTH) begin
        frame_buf[buf_fill] = rx_byte;
        buf_fill++;
      end
      if (session == RECEIVING && buf_fill >= xfr_pkg::FRAME_BYTES) judge_frame();
    end else begin
      if (tick_count != 0) tick_count--;
      if (tick_count == 0) begin
        if (session == RECEIVING) begin
          judge_frame();
        end else begin
          queue_beat(xfr_pkg::ACT_ACK, '0, '0, 1'b1, next_addr);
          session = SESSION_DONE;
        end
      end
    end
    if (expected_beats.size() > n0) begin
      tail = expected_beats.pop_back();
      tail.last = 1'b1;
      expected_beats.push_back(tail);
    end
  endtask

  task automatic write_reg(logic [xfr_pkg::CFG_IDX_W-1:0] idx,
                           logic [xfr_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      xfr_pkg::REG_BASE:     next_addr = data;
      xfr_pkg::REG_LIMIT:    limit_reg = data;
      xfr_pkg::REG_TIMEOUT:  timeout_reg = data[7:0];
      xfr_pkg::REG_EOT_WAIT: eot_wait_reg = data[7:0];
      default:      ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] safe_byte();
    logic [7:0] b;
    b = 8'($urandom);
    return (b == xfr_pkg::LEAD_EOT) ? ~b : b;
  endfunction

  task automatic push_byte(logic [7:0] b);
    rx_events.push_back('{1'b0, b});
    queued_items++;
  endtask

  task automatic push_ticks(int n);
    repeat (n) begin
      rx_events.push_back('{1'b1, 8'($urandom)});
      queued_items++;
    end
  endtask

  task automatic push_frame(logic [7:0] lead, int body);
    push_byte(lead);
    repeat (body) push_byte(safe_byte());
  endtask

  task automatic settle();
    do @(negedge clk);
    while (rx_events.size() != 0 || rx_ch.valid || expected_beats.size() != 0);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %h, got %h", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_ch.valid   <= 1'b0;
      rx_ch.func    <= 1'b0;
      rx_ch.rx_byte <= 8'h00;
    end else begin
      if (rx_ch.valid && rx_ch.ready) predict_beat(rx_ch.func, rx_ch.rx_byte);
      if (!rx_ch.valid || rx_ch.ready) begin
        if (rx_events.size() != 0 && (calm || $urandom_range(99) >= 14)) begin
          offered = rx_events.pop_front();
          rx_ch.valid   <= 1'b1;
          rx_ch.func    <= offered.func;
          rx_ch.rx_byte <= offered.rx_byte;
        end else begin
          rx_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      tx_ch.ready <= 1'b0;
    end else begin
      if (tx_ch.valid && tx_ch.ready) begin
        if (expected_beats.size() == 0) begin
          $error("unexpected beat: action %0d address %h word %h",
                 tx_ch.action, tx_ch.flash_address, tx_ch.flash_word);
          fail_count++;
        end else begin
          want = expected_beats.pop_front();
          check_field("action", 32'(want.action), 32'(tx_ch.action));
          check_field("flash_address", want.flash_address, tx_ch.flash_address);
          check_field("flash_word", want.flash_word, tx_ch.flash_word);
          check_field("session_done", 32'(want.session_done), 32'(tx_ch.session_done));
          check_field("end_address", want.end_address, tx_ch.end_address);
          check_field("last", 32'(want.last), 32'(tx_ch.last));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        tx_ch.ready <= 1'b0;
      end else if (!held_once && tx_ch.valid && tx_ch.action == xfr_pkg::ACT_WRITE) begin
        // hold off while the sender keeps offering, so the block fills up
        held_once = 1'b1;
        hold_left = HOLD_CYCLES;
        tx_ch.ready <= 1'b0;
      end else begin
        tx_ch.ready <= calm || $urandom_range(99) >= 14;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && !((rx_ch.valid && rx_ch.ready) || (tx_ch.valid && tx_ch.ready))) begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("[xmodem_frame_receiver_unit] ERROR");
        $finish;
      end
    end else begin
      stall_cycles = 0;
    end
  end

  initial begin
    logic [31:0] base;
    logic [31:0] limit;
    logic [7:0]  lead;
    int          tmo;
    int          start;
    int          pick;

    fail_count   = 0;
    stall_cycles = 0;
    hold_left    = 0;
    queued_items = 0;
    held_once    = 1'b0;
    calm         = 1'b0;
    clear_frame();
    next_addr    = xfr_pkg::BASE_RST;
    limit_reg    = xfr_pkg::LIMIT_RST;
    timeout_reg  = xfr_pkg::TIMEOUT_RST;
    eot_wait_reg = xfr_pkg::EOT_WAIT_RST;
    tick_count   = xfr_pkg::TIMEOUT_RST;
    session      = RECEIVING;

    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_wdata     <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // full frame at the reset addresses reloads the timer with a zero timeout
    write_reg(xfr_pkg::REG_TIMEOUT, 32'd0);
    push_frame(xfr_pkg::LEAD_SOH, xfr_pkg::FRAME_BYTES - 1);
    push_ticks(1);
    push_byte(xfr_pkg::LEAD_SOH);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'hFF);
    push_byte(8'h80);
    push_byte(8'h00);
    push_byte(8'h7F);
    push_ticks(1);
    push_byte(8'h15);
    push_ticks(1);
    push_byte(8'hFF);
    push_ticks(1);
    push_byte(8'h00);
    push_byte(xfr_pkg::LEAD_SOH);
    push_ticks(1);
    settle();

    // wrap through the top of the address space
    write_reg(xfr_pkg::REG_BASE, 32'hFFFF_FFC0);
    write_reg(xfr_pkg::REG_LIMIT, 32'hFFFF_FFFF);
    write_reg(xfr_pkg::REG_TIMEOUT, 32'd1);
    push_frame(xfr_pkg::LEAD_SOH, 6);
    push_ticks(1);
    push_frame(xfr_pkg::LEAD_SOH, 4);
    push_ticks(1);
    settle();

    // write address at the limit
    write_reg(xfr_pkg::REG_BASE, 32'h0000_0000);
    write_reg(xfr_pkg::REG_LIMIT, 32'h0000_0000);
    push_frame(xfr_pkg::LEAD_SOH, 3);
    push_ticks(1);
    settle();
    write_reg(xfr_pkg::REG_EOT_WAIT, 32'd0);

    for (int ph = 0; ph < 4; ph++) begin
      base = $urandom;
      case ($urandom_range(3))
        0: limit = 32'hFFFF_FFFF;
        1: begin
          base  = 32'hFFFF_FF00 | 32'($urandom_range(255));
          limit = 32'hFFFF_FFFF;
        end
        2: limit = base + 32'($urandom_range(1, 3)) * xfr_pkg::DATA_BYTES;
        default: limit = $urandom;
      endcase
      write_reg(xfr_pkg::REG_BASE, base);
      write_reg(xfr_pkg::REG_LIMIT, limit);
      write_reg(xfr_pkg::REG_TIMEOUT, 32'($urandom_range(0, 4)));
      write_reg(xfr_pkg::REG_EOT_WAIT, 32'($urandom_range(0, 255)));
      tmo = (timeout_reg == 0) ? 1 : int'(timeout_reg);
      start = queued_items;
      while (queued_items - start < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 55) begin
          push_frame(xfr_pkg::LEAD_SOH, $urandom_range(0, 10));
          push_ticks(tmo);
        end else if (pick < 75) begin
          lead = safe_byte();
          if (lead == xfr_pkg::LEAD_SOH) lead = ~lead;
          push_frame(lead, $urandom_range(0, 6));
          push_ticks(tmo);
        end else if (pick < 85) begin
          push_ticks(tmo);
        end else begin
          repeat ($urandom_range(1, 5)) begin
            if ($urandom_range(1)) push_byte(safe_byte());
            else push_ticks(1);
          end
        end
      end
      // flush whatever frame is still open
      push_ticks(tmo);
      settle();
    end

    // stretch with no idling on either side
    calm = 1'b1;
    write_reg(xfr_pkg::REG_TIMEOUT, 32'd6);
    push_frame(xfr_pkg::LEAD_SOH, 20);
    push_ticks(6);
    settle();
    calm = 1'b0;

    // close the session: bytes during the wait are stored, then inputs are ignored
    write_reg(xfr_pkg::REG_EOT_WAIT, 32'd16);
    push_frame(xfr_pkg::LEAD_EOT, 4);
    push_ticks(6);
    repeat (6) begin
      push_byte(8'($urandom));
      push_ticks(1);
    end
    push_ticks(12);
    repeat (3) begin
      push_byte(8'($urandom));
      push_ticks(1);
    end
    settle();

    if (fail_count == 0) $display("[xmodem_frame_receiver_unit] OK");
    else $display("[xmodem_frame_receiver_unit] ERROR");
    $finish;
  end

endmodule

/* sim.f */
design/xfr_pkg.sv
design/xfr_if.sv
design/xfr_store.sv
design/xfr_seq.sv
design/xmodem_frame_receiver_unit.sv
test/tb_xmodem_frame_receiver_unit.sv
